[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tnopt_pkg.sv]
// Types and constants for the Telnet option negotiator.
package tnopt_pkg;

   localparam int OPTION_COUNT_DEF = 256;
   localparam int OPT_W            = 8;
   localparam int MODE_W           = 3;
   localparam int ENTRY_W          = 6;
   localparam int SIDE_W           = 3;

   localparam logic [7:0] CMD_WILL = 8'd251;
   localparam logic [7:0] CMD_WONT = 8'd252;
   localparam logic [7:0] CMD_DO   = 8'd253;
   localparam logic [7:0] CMD_DONT = 8'd254;
   localparam logic [7:0] CMD_NONE = 8'd0;

   typedef enum logic [1:0] {
      ST_NO      = 2'd0,
      ST_YES     = 2'd1,
      ST_WANTNO  = 2'd2,
      ST_WANTYES = 2'd3
   } side_state_type;

   typedef enum logic [1:0] {
      EV_GOT_ENABLE  = 2'd0,
      EV_GOT_DISABLE = 2'd1,
      EV_ASK_ENABLE  = 2'd2,
      EV_ASK_DISABLE = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      SEND_NONE    = 2'd0,
      SEND_ACCEPT  = 2'd1,
      SEND_DECLINE = 2'd2
   } send_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_DIS_ANSWERED  = 3'd1,
      ERR_ALREADY_EN    = 3'd2,
      ERR_EN_QUEUED     = 3'd3,
      ERR_NEGOT_EN      = 3'd4,
      ERR_ALREADY_DIS   = 3'd5,
      ERR_NEGOT_DIS     = 3'd6,
      ERR_DIS_QUEUED    = 3'd7
   } error_type;

   typedef struct packed {
      event_kind_type kind;
      side_state_type state;
      logic           queue;
      logic           permit;
   } side_in_type;

   typedef struct packed {
      side_state_type state;
      logic           queue;
      send_kind_type  send;
      logic           notify_valid;
      logic           notify_enable;
      error_type      error;
   } side_out_type;

endpackage

[hw/rtl/tnopt_side.sv]
// Q-method transition logic for one side (local or remote) of an option.
module tnopt_side (
   input  tnopt_pkg::side_in_type  side_in,
   output tnopt_pkg::side_out_type side_out
);

   always_comb begin
      side_out               = '0;
      side_out.state         = side_in.state;
      side_out.queue         = side_in.queue;
      side_out.send          = tnopt_pkg::SEND_NONE;
      side_out.error         = tnopt_pkg::ERR_NONE;
      case (side_in.kind)
         tnopt_pkg::EV_GOT_ENABLE: begin
            case (side_in.state)
               tnopt_pkg::ST_NO: begin
                  if (side_in.permit) begin
                     side_out.state         = tnopt_pkg::ST_YES;
                     side_out.send          = tnopt_pkg::SEND_ACCEPT;
                     side_out.notify_valid  = 1'b1;
                     side_out.notify_enable = 1'b1;
                  end else begin
                     side_out.send = tnopt_pkg::SEND_DECLINE;
                  end
               end
               tnopt_pkg::ST_WANTNO: begin
                  side_out.error = tnopt_pkg::ERR_DIS_ANSWERED;
                  if (!side_in.queue) begin
                     side_out.state = tnopt_pkg::ST_NO;
                  end else begin
                     side_out.state         = tnopt_pkg::ST_YES;
                     side_out.queue         = 1'b0;
                     side_out.notify_valid  = 1'b1;
                     side_out.notify_enable = 1'b1;
                  end
               end
               tnopt_pkg::ST_WANTYES: begin
                  if (!side_in.queue) begin
                     side_out.state         = tnopt_pkg::ST_YES;
                     side_out.notify_valid  = 1'b1;
                     side_out.notify_enable = 1'b1;
                  end else begin
                     side_out.state = tnopt_pkg::ST_WANTNO;
                     side_out.queue = 1'b0;
                     side_out.send  = tnopt_pkg::SEND_DECLINE;
                  end
               end
               default: begin
               end
            endcase
         end
         tnopt_pkg::EV_GOT_DISABLE: begin
            case (side_in.state)
               tnopt_pkg::ST_YES: begin
                  side_out.state        = tnopt_pkg::ST_NO;
                  side_out.send         = tnopt_pkg::SEND_DECLINE;
                  side_out.notify_valid = 1'b1;
               end
               tnopt_pkg::ST_WANTNO: begin
                  if (!side_in.queue) begin
                     side_out.state = tnopt_pkg::ST_NO;
                  end else begin
                     side_out.state = tnopt_pkg::ST_WANTYES;
                     side_out.queue = 1'b0;
                     side_out.send  = tnopt_pkg::SEND_ACCEPT;
                  end
               end
               tnopt_pkg::ST_WANTYES: begin
                  side_out.state = tnopt_pkg::ST_NO;
                  side_out.queue = 1'b0;
               end
               default: begin
               end
            endcase
         end
         tnopt_pkg::EV_ASK_ENABLE: begin
            case (side_in.state)
               tnopt_pkg::ST_NO: begin
                  side_out.state = tnopt_pkg::ST_WANTYES;
                  side_out.send  = tnopt_pkg::SEND_ACCEPT;
               end
               tnopt_pkg::ST_YES: side_out.error = tnopt_pkg::ERR_ALREADY_EN;
               tnopt_pkg::ST_WANTNO: begin
                  if (!side_in.queue) side_out.queue = 1'b1;
                  else                side_out.error = tnopt_pkg::ERR_EN_QUEUED;
               end
               default: begin
                  if (!side_in.queue) side_out.error = tnopt_pkg::ERR_NEGOT_EN;
                  else                side_out.queue = 1'b0;
               end
            endcase
         end
         default: begin
            case (side_in.state)
               tnopt_pkg::ST_NO: side_out.error = tnopt_pkg::ERR_ALREADY_DIS;
               tnopt_pkg::ST_YES: begin
                  // A local disable reports the side as gone at once.
                  side_out.state        = tnopt_pkg::ST_WANTNO;
                  side_out.send         = tnopt_pkg::SEND_DECLINE;
                  side_out.notify_valid = 1'b1;
               end
               tnopt_pkg::ST_WANTNO: begin
                  if (!side_in.queue) side_out.error = tnopt_pkg::ERR_NEGOT_DIS;
                  else                side_out.queue = 1'b0;
               end
               default: begin
                  if (!side_in.queue) side_out.queue = 1'b1;
                  else                side_out.error = tnopt_pkg::ERR_DIS_QUEUED;
               end
            endcase
         end
      endcase
   end

endmodule

[hw/rtl/telnet_option_negotiator_unit.sv]
// Top level of the Telnet Q-method option negotiator: option table and result stage.
//
//   channel  direction  handshake              payload
//   request  in         start & !busy          req_mode, req_option, req_permit
//   response out        rsp_strobe (one cycle) rsp_send_*, rsp_notify_*, rsp_error_code,
//                                              rsp_local_enabled, rsp_remote_enabled
//
// A transaction's entry is first read from the synchronous table into a register;
// the update and its result then go into the output register.
// A new transaction can be accepted every cycle while busy is low; a
// write-to-read forwarding register covers back-to-back transactions on the same option.
// Synchronous reset clears one valid bit per table entry, so an entry not yet
// written reads as both sides NO with empty queues; no clearing pass is needed.
// busy is high during reset and in the cycle that follows it. The receiver cannot stall.
`include "assert_macros.svh"

module telnet_option_negotiator_unit #(
   parameter int OPTION_COUNT = tnopt_pkg::OPTION_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tnopt_pkg::MODE_W-1:0]  req_mode,
   input  logic [tnopt_pkg::OPT_W-1:0]   req_option,
   input  logic                          req_permit,
   output logic                          rsp_strobe,
   output logic                          rsp_send_valid,
   output logic [7:0]                    rsp_send_command,
   output logic [tnopt_pkg::OPT_W-1:0]   rsp_send_option,
   output logic                          rsp_notify_valid,
   output logic                          rsp_notify_enable,
   output logic                          rsp_notify_remote,
   output logic [2:0]                    rsp_error_code,
   output logic                          rsp_local_enabled,
   output logic                          rsp_remote_enabled
);

   localparam int IDX_W = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;
   localparam int CNT_W = tnopt_pkg::OPT_W + 1;

   // Accept and range check of the incoming transaction.
   logic             accept;
   logic             req_in_range;
   logic [IDX_W-1:0] req_addr;

   // Option table: one 6-bit entry per option plus a reset-cleared valid bit.
   logic [tnopt_pkg::ENTRY_W-1:0] table_mem [OPTION_COUNT];
   logic [OPTION_COUNT-1:0]       vld_ff;
   logic [tnopt_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                          rd_valid_ff;

   // Forwarding of the entry written in the same cycle as the read.
   logic                          fwd_hit_ff;
   logic [tnopt_pkg::ENTRY_W-1:0] fwd_data_ff;

   // Transaction held while its table entry is read.
   logic                          s1_valid_ff;
   logic                          s1_in_range_ff;
   logic [tnopt_pkg::MODE_W-1:0]  s1_mode_ff;
   logic [tnopt_pkg::OPT_W-1:0]   s1_option_ff;
   logic                          s1_permit_ff;
   logic [IDX_W-1:0]              s1_addr_ff;

   logic                          busy_ff;

   // Update path.
   logic [tnopt_pkg::ENTRY_W-1:0] entry_cur;
   logic [tnopt_pkg::ENTRY_W-1:0] entry_new;
   logic                          remote;
   logic [tnopt_pkg::SIDE_W-1:0]  side_bits;
   logic                          wr_en;
   tnopt_pkg::side_in_type        side_in;
   tnopt_pkg::side_out_type       side_out;
   logic [7:0]                    cmd_byte;

   // Response register and its next value.
   logic                          rsp_strobe_ff;
   logic                          send_valid_ff,  send_valid_in;
   logic [7:0]                    send_cmd_ff,    send_cmd_in;
   logic [tnopt_pkg::OPT_W-1:0]   send_opt_ff;
   logic                          notify_valid_ff, notify_valid_in;
   logic                          notify_en_ff,   notify_en_in;
   logic                          notify_rem_ff,  notify_rem_in;
   logic [2:0]                    error_ff,       error_in;
   logic                          local_en_ff,    local_en_in;
   logic                          remote_en_ff,   remote_en_in;

   assign accept       = start && !busy_ff;
   assign req_in_range = {1'b0, req_option} < CNT_W'(OPTION_COUNT);
   assign req_addr     = req_option[IDX_W-1:0];

   // Synchronous table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[s1_addr_ff] <= entry_new;
      end
      if (accept && req_in_range) begin
         rd_data_ff <= table_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[s1_addr_ff] <= 1'b1;
         end
         if (accept) begin
            rd_valid_ff <= req_in_range && vld_ff[req_addr];
            // The write at this edge is not yet visible to the read; catch it.
            fwd_hit_ff  <= wr_en && (s1_addr_ff == req_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= entry_new;
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         busy_ff     <= 1'b1;
      end else begin
         s1_valid_ff <= accept;
         busy_ff     <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_in_range_ff <= req_in_range;
         s1_mode_ff     <= req_mode;
         s1_option_ff   <= req_option;
         s1_permit_ff   <= req_permit;
         s1_addr_ff     <= req_addr;
      end
   end

   // Current entry: forwarded write, stored value, or the reset value.
   always_comb begin
      if (fwd_hit_ff) begin
         entry_cur = fwd_data_ff;
      end else if (rd_valid_ff) begin
         entry_cur = rd_data_ff;
      end else begin
         entry_cur = '0;
      end
   end

   // Even modes address the remote side, whose bits sit in the upper half.
   assign remote    = !s1_mode_ff[0];
   assign side_bits = remote ? entry_cur[5:3] : entry_cur[2:0];

   assign side_in.kind   = tnopt_pkg::event_kind_type'(s1_mode_ff[2:1]);
   assign side_in.state  = tnopt_pkg::side_state_type'(side_bits[1:0]);
   assign side_in.queue  = side_bits[2];
   assign side_in.permit = s1_permit_ff;

   tnopt_side u_side (
      .side_in  (side_in),
      .side_out (side_out)
   );

   always_comb begin
      if (remote) begin
         entry_new = {side_out.queue, side_out.state, entry_cur[2:0]};
      end else begin
         entry_new = {entry_cur[5:3], side_out.queue, side_out.state};
      end
   end

   assign wr_en = s1_valid_ff && s1_in_range_ff;

   always_comb begin
      case (side_out.send)
         tnopt_pkg::SEND_ACCEPT:  cmd_byte = remote ? tnopt_pkg::CMD_DO : tnopt_pkg::CMD_WILL;
         tnopt_pkg::SEND_DECLINE: cmd_byte = remote ? tnopt_pkg::CMD_DONT : tnopt_pkg::CMD_WONT;
         default:                 cmd_byte = tnopt_pkg::CMD_NONE;
      endcase
   end

   // An option beyond the table gives an empty response that only echoes it.
   always_comb begin
      if (s1_in_range_ff) begin
         send_valid_in   = side_out.send != tnopt_pkg::SEND_NONE;
         send_cmd_in     = cmd_byte;
         notify_valid_in = side_out.notify_valid;
         notify_en_in    = side_out.notify_valid && side_out.notify_enable;
         notify_rem_in   = side_out.notify_valid && remote;
         error_in        = side_out.error;
         local_en_in     = entry_new[1:0] == tnopt_pkg::ST_YES;
         remote_en_in    = entry_new[4:3] == tnopt_pkg::ST_YES;
      end else begin
         send_valid_in   = 1'b0;
         send_cmd_in     = tnopt_pkg::CMD_NONE;
         notify_valid_in = 1'b0;
         notify_en_in    = 1'b0;
         notify_rem_in   = 1'b0;
         error_in        = tnopt_pkg::ERR_NONE;
         local_en_in     = 1'b0;
         remote_en_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         send_valid_ff   <= send_valid_in;
         send_cmd_ff     <= send_cmd_in;
         send_opt_ff     <= s1_option_ff;
         notify_valid_ff <= notify_valid_in;
         notify_en_ff    <= notify_en_in;
         notify_rem_ff   <= notify_rem_in;
         error_ff        <= error_in;
         local_en_ff     <= local_en_in;
         remote_en_ff    <= remote_en_in;
      end
   end

   assign busy               = busy_ff;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_send_valid     = send_valid_ff;
   assign rsp_send_command   = send_cmd_ff;
   assign rsp_send_option    = send_opt_ff;
   assign rsp_notify_valid   = notify_valid_ff;
   assign rsp_notify_enable  = notify_en_ff;
   assign rsp_notify_remote  = notify_rem_ff;
   assign rsp_error_code     = error_ff;
   assign rsp_local_enabled  = local_en_ff;
   assign rsp_remote_enabled = remote_en_ff;

   // Every accepted transaction yields its response once it has passed the read and output registers.
   `ASSERT_NEXT(a_rsp_latency, clock, reset, start && !busy, ##1 rsp_strobe, "response missing after accepted transaction")

   // A command byte is sent only as one of the four negotiation commands.
   `ASSERT_IMPLY(a_cmd_legal, clock, reset, rsp_strobe && rsp_send_valid, (rsp_send_command == tnopt_pkg::CMD_WILL) || (rsp_send_command == tnopt_pkg::CMD_WONT) || (rsp_send_command == tnopt_pkg::CMD_DO) || (rsp_send_command == tnopt_pkg::CMD_DONT), "illegal command byte")

   // An enable notification matches the enabled flag of the side it names.
   `ASSERT_IMPLY(a_notify_flag, clock, reset, rsp_strobe && rsp_notify_valid && rsp_notify_enable, rsp_notify_remote ? rsp_remote_enabled : rsp_local_enabled, "enable notification on a side that is not enabled")

endmodule

[dv/telnet_option_negotiator_unit_tb.sv]
// Self-checking testbench for the Telnet Q-method option negotiator top level.
module telnet_option_negotiator_unit_tb;

   // The table is built at its full size, so every 8-bit option code has an entry.
   localparam int TABLE_DEPTH = tnopt_pkg::OPTION_COUNT_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_EVENTS = 1250;
   localparam int PHASE_LENGTH = 160;
   localparam int REPORT_LIMIT = 10;
   localparam int DRAIN_CYCLES = 10;

   // Request mode codes. Even modes address the remote side (him), odd ones the
   // local side (us). The upper two bits select the event kind.
   localparam logic [tnopt_pkg::MODE_W-1:0] MODE_GOT_WILL        = 3'd0;
   localparam logic [tnopt_pkg::MODE_W-1:0] MODE_GOT_DO          = 3'd1;
   localparam logic [tnopt_pkg::MODE_W-1:0] MODE_GOT_WONT        = 3'd2;
   localparam logic [tnopt_pkg::MODE_W-1:0] MODE_GOT_DONT        = 3'd3;
   localparam logic [tnopt_pkg::MODE_W-1:0] MODE_ASK_HIM_ENABLE  = 3'd4;
   localparam logic [tnopt_pkg::MODE_W-1:0] MODE_ASK_US_ENABLE   = 3'd5;
   localparam logic [tnopt_pkg::MODE_W-1:0] MODE_ASK_HIM_DISABLE = 3'd6;
   localparam logic [tnopt_pkg::MODE_W-1:0] MODE_ASK_US_DISABLE  = 3'd7;

   // One negotiation event as the driver sends it.
   typedef struct packed {
      logic [tnopt_pkg::MODE_W-1:0] mode;
      logic [tnopt_pkg::OPT_W-1:0]  option;
      logic                         permit;
   } negotiation_event_type;

   // Both sides of one option table entry.
   typedef struct packed {
      logic                      him_queue;
      tnopt_pkg::side_state_type him_state;
      logic                      us_queue;
      tnopt_pkg::side_state_type us_state;
   } option_entry_type;

   // One response transaction, field by field.
   typedef struct packed {
      logic                        send_valid;
      logic [7:0]                  send_command;
      logic [tnopt_pkg::OPT_W-1:0] send_option;
      logic                        notify_valid;
      logic                        notify_enable;
      logic                        notify_remote;
      tnopt_pkg::error_type        error_code;
      logic                        local_enabled;
      logic                        remote_enabled;
   } negotiation_reply_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [tnopt_pkg::MODE_W-1:0] req_mode = '0;
   logic [tnopt_pkg::OPT_W-1:0]  req_option = '0;
   logic                         req_permit = 1'b0;
   logic                         rsp_strobe;
   logic                         rsp_send_valid;
   logic [7:0]                   rsp_send_command;
   logic [tnopt_pkg::OPT_W-1:0]  rsp_send_option;
   logic                         rsp_notify_valid;
   logic                         rsp_notify_enable;
   logic                         rsp_notify_remote;
   logic [2:0]                   rsp_error_code;
   logic                         rsp_local_enabled;
   logic                         rsp_remote_enabled;

   // Events still to be sent, replies predicted but not yet seen, and the
   // testbench's own copy of the option table.
   negotiation_event_type pending_events[$];
   negotiation_reply_type awaited_replies[$];
   option_entry_type      option_table[TABLE_DEPTH];

   int accepted_count = 0;
   int fault_count = 0;
   int cycle_count = 0;

   telnet_option_negotiator_unit #(
      .OPTION_COUNT(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_option(req_option),
      .req_permit(req_permit),
      .rsp_strobe(rsp_strobe),
      .rsp_send_valid(rsp_send_valid),
      .rsp_send_command(rsp_send_command),
      .rsp_send_option(rsp_send_option),
      .rsp_notify_valid(rsp_notify_valid),
      .rsp_notify_enable(rsp_notify_enable),
      .rsp_notify_remote(rsp_notify_remote),
      .rsp_error_code(rsp_error_code),
      .rsp_local_enabled(rsp_local_enabled),
      .rsp_remote_enabled(rsp_remote_enabled)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one accepted event to the table copy and queues the reply it must
   // produce. This follows the Q method: each side has a state and a one-bit queue
   // that remembers a request for the opposite state while a negotiation runs.
   task automatic apply_negotiation_event(input negotiation_event_type ev);
      negotiation_reply_type     reply;
      option_entry_type          entry;
      tnopt_pkg::side_state_type side_state;
      logic                      side_queue;
      logic                      remote;
      logic [7:0]                accept_cmd;
      logic [7:0]                decline_cmd;
      logic [7:0]                cmd;
      tnopt_pkg::error_type      err;
      logic                      notify;
      logic                      enable;

      reply = '0;
      reply.send_option = ev.option;
      // An option beyond the table is ignored and answered with an empty reply.
      if (ev.option >= TABLE_DEPTH) begin
         awaited_replies.push_back(reply);
         return;
      end

      remote = ~ev.mode[0];
      accept_cmd = remote ? tnopt_pkg::CMD_DO : tnopt_pkg::CMD_WILL;
      decline_cmd = remote ? tnopt_pkg::CMD_DONT : tnopt_pkg::CMD_WONT;
      entry = option_table[ev.option];
      side_state = remote ? entry.him_state : entry.us_state;
      side_queue = remote ? entry.him_queue : entry.us_queue;
      cmd = tnopt_pkg::CMD_NONE;
      err = tnopt_pkg::ERR_NONE;
      notify = 1'b0;
      enable = 1'b0;

      case (tnopt_pkg::event_kind_type'(ev.mode[2:1]))
         tnopt_pkg::EV_GOT_ENABLE: begin
            case (side_state)
               tnopt_pkg::ST_NO: begin
                  if (ev.permit) begin
                     side_state = tnopt_pkg::ST_YES;
                     cmd = accept_cmd;
                     notify = 1'b1;
                     enable = 1'b1;
                  end else begin
                     cmd = decline_cmd;
                  end
               end
               // Our disable was answered by an enable. A queued enable request
               // turns this into a completed enable.
               tnopt_pkg::ST_WANTNO: begin
                  err = tnopt_pkg::ERR_DIS_ANSWERED;
                  if (!side_queue) begin
                     side_state = tnopt_pkg::ST_NO;
                  end else begin
                     side_state = tnopt_pkg::ST_YES;
                     side_queue = 1'b0;
                     notify = 1'b1;
                     enable = 1'b1;
                  end
               end
               tnopt_pkg::ST_WANTYES: begin
                  if (!side_queue) begin
                     side_state = tnopt_pkg::ST_YES;
                     notify = 1'b1;
                     enable = 1'b1;
                  end else begin
                     side_state = tnopt_pkg::ST_WANTNO;
                     side_queue = 1'b0;
                     cmd = decline_cmd;
                  end
               end
               default: begin
               end
            endcase
         end
         tnopt_pkg::EV_GOT_DISABLE: begin
            case (side_state)
               tnopt_pkg::ST_YES: begin
                  side_state = tnopt_pkg::ST_NO;
                  cmd = decline_cmd;
                  notify = 1'b1;
               end
               tnopt_pkg::ST_WANTNO: begin
                  if (!side_queue) begin
                     side_state = tnopt_pkg::ST_NO;
                  end else begin
                     side_state = tnopt_pkg::ST_WANTYES;
                     side_queue = 1'b0;
                     cmd = accept_cmd;
                  end
               end
               tnopt_pkg::ST_WANTYES: begin
                  side_state = tnopt_pkg::ST_NO;
                  side_queue = 1'b0;
               end
               default: begin
               end
            endcase
         end
         tnopt_pkg::EV_ASK_ENABLE: begin
            case (side_state)
               tnopt_pkg::ST_NO: begin
                  side_state = tnopt_pkg::ST_WANTYES;
                  cmd = accept_cmd;
               end
               tnopt_pkg::ST_YES: err = tnopt_pkg::ERR_ALREADY_EN;
               tnopt_pkg::ST_WANTNO: begin
                  if (!side_queue) side_queue = 1'b1;
                  else err = tnopt_pkg::ERR_EN_QUEUED;
               end
               default: begin
                  if (!side_queue) err = tnopt_pkg::ERR_NEGOT_EN;
                  else side_queue = 1'b0;
               end
            endcase
         end
         default: begin
            case (side_state)
               tnopt_pkg::ST_NO: err = tnopt_pkg::ERR_ALREADY_DIS;
               // A local disable from YES reports the disable right away,
               // before the peer has answered.
               tnopt_pkg::ST_YES: begin
                  side_state = tnopt_pkg::ST_WANTNO;
                  cmd = decline_cmd;
                  notify = 1'b1;
               end
               tnopt_pkg::ST_WANTNO: begin
                  if (!side_queue) err = tnopt_pkg::ERR_NEGOT_DIS;
                  else side_queue = 1'b0;
               end
               default: begin
                  if (!side_queue) side_queue = 1'b1;
                  else err = tnopt_pkg::ERR_DIS_QUEUED;
               end
            endcase
         end
      endcase

      if (remote) begin
         entry.him_state = side_state;
         entry.him_queue = side_queue;
      end else begin
         entry.us_state = side_state;
         entry.us_queue = side_queue;
      end
      option_table[ev.option] = entry;

      reply.send_valid = (cmd != tnopt_pkg::CMD_NONE);
      reply.send_command = cmd;
      reply.notify_valid = notify;
      reply.notify_enable = notify & enable;
      reply.notify_remote = notify & remote;
      reply.error_code = err;
      reply.local_enabled = (entry.us_state == tnopt_pkg::ST_YES);
      reply.remote_enabled = (entry.him_state == tnopt_pkg::ST_YES);
      awaited_replies.push_back(reply);
   endtask

   task automatic queue_event(input logic [tnopt_pkg::MODE_W-1:0] mode,
                              input logic [tnopt_pkg::OPT_W-1:0] option,
                              input logic permit);
      negotiation_event_type ev;

      ev.mode = mode;
      ev.option = option;
      ev.permit = permit;
      pending_events.push_back(ev);
   endtask

   // Driver. A transaction is accepted at an edge where start is high and busy is
   // low; the prediction is made right there from the values that were driven.
   // The next event, or an idle cycle, is chosen in the same step, and start gets
   // at most one assignment per edge. Sender idling cycles through four phases
   // of PHASE_LENGTH accepted transactions: none, heavy, none again (the receiver
   // cannot stall, so its phase has no effect), and light.
   always @(posedge clock) begin
      negotiation_event_type ev;
      int                    idle_percent;
      logic                  taken;

      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            ev.mode = req_mode;
            ev.option = req_option;
            ev.permit = req_permit;
            apply_negotiation_event(ev);
            accepted_count++;
         end
         case ((accepted_count / PHASE_LENGTH) % 4)
            1: idle_percent = 66;
            3: idle_percent = 18;
            default: idle_percent = 0;
         endcase
         // An offered transaction that was not taken stays on the ports untouched.
         if (!start || taken) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= idle_percent) begin
               ev = pending_events.pop_front();
               start <= 1'b1;
               req_mode <= ev.mode;
               req_option <= ev.option;
               req_permit <= ev.permit;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every strobed response is checked against the oldest predicted
   // reply; a response with nothing awaited is a failure as well.
   always @(posedge clock) begin
      negotiation_reply_type seen;
      negotiation_reply_type want;

      if (!reset && rsp_strobe) begin
         seen.send_valid = rsp_send_valid;
         seen.send_command = rsp_send_command;
         seen.send_option = rsp_send_option;
         seen.notify_valid = rsp_notify_valid;
         seen.notify_enable = rsp_notify_enable;
         seen.notify_remote = rsp_notify_remote;
         seen.error_code = tnopt_pkg::error_type'(rsp_error_code);
         seen.local_enabled = rsp_local_enabled;
         seen.remote_enabled = rsp_remote_enabled;
         if (awaited_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("response with no transaction outstanding: option %0d cmd %0d",
                        seen.send_option, seen.send_command);
         end else begin
            want = awaited_replies.pop_front();
            if (seen.send_valid !== want.send_valid
                  || seen.send_command !== want.send_command
                  || seen.send_option !== want.send_option
                  || seen.notify_valid !== want.notify_valid
                  || seen.notify_enable !== want.notify_enable
                  || seen.notify_remote !== want.notify_remote
                  || seen.error_code !== want.error_code
                  || seen.local_enabled !== want.local_enabled
                  || seen.remote_enabled !== want.remote_enabled) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("mismatch at cycle %0d, option %0d", cycle_count,
                           want.send_option);
                  $display({"  expected: send %b cmd %0d opt %0d notify %b en %b",
                            " rem %b err %0d loc %b rmt %b"},
                           want.send_valid, want.send_command, want.send_option,
                           want.notify_valid, want.notify_enable, want.notify_remote,
                           want.error_code, want.local_enabled, want.remote_enabled);
                  $display({"  actual:   send %b cmd %0d opt %0d notify %b en %b",
                            " rem %b err %0d loc %b rmt %b"},
                           seen.send_valid, seen.send_command, seen.send_option,
                           seen.notify_valid, seen.notify_enable, seen.notify_remote,
                           seen.error_code, seen.local_enabled, seen.remote_enabled);
               end
            end
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL telnet_option_negotiator_unit");
         $finish;
      end
   end

   initial begin
      int                           pick;
      int                           rnd;
      logic [2:0]                   hot_pick;
      logic [tnopt_pkg::MODE_W-1:0] mode_pick;
      logic [tnopt_pkg::OPT_W-1:0]  option_pick;
      logic [tnopt_pkg::OPT_W-1:0]  hot_options[6];

      foreach (option_table[i]) option_table[i] = '0;

      // Directed part. The local side of option 255 walks through the special
      // cases: a local disable from YES notifies at once, and an enable answering
      // our disable is an error that either completes a queued enable or falls
      // back to NO.
      queue_event(MODE_ASK_US_ENABLE, 8'd255, 1'b0);
      queue_event(MODE_GOT_DO, 8'd255, 1'b0);
      queue_event(MODE_ASK_US_DISABLE, 8'd255, 1'b1);
      queue_event(MODE_ASK_US_ENABLE, 8'd255, 1'b0);
      queue_event(MODE_GOT_DO, 8'd255, 1'b1);
      queue_event(MODE_ASK_US_DISABLE, 8'd255, 1'b0);
      queue_event(MODE_GOT_DO, 8'd255, 1'b1);
      queue_event(MODE_GOT_DO, 8'd255, 1'b1);
      queue_event(MODE_GOT_DONT, 8'd255, 1'b0);
      queue_event(MODE_GOT_DO, 8'd255, 1'b0);
      // The remote side of option 0 goes through every local request error but ERR_EN_QUEUED.
      queue_event(MODE_GOT_WILL, 8'd0, 1'b1);
      queue_event(MODE_ASK_HIM_ENABLE, 8'd0, 1'b0);
      queue_event(MODE_GOT_WONT, 8'd0, 1'b0);
      queue_event(MODE_ASK_HIM_DISABLE, 8'd0, 1'b0);
      queue_event(MODE_ASK_HIM_ENABLE, 8'd0, 1'b1);
      queue_event(MODE_ASK_HIM_ENABLE, 8'd0, 1'b0);
      queue_event(MODE_ASK_HIM_DISABLE, 8'd0, 1'b0);
      queue_event(MODE_ASK_HIM_DISABLE, 8'd0, 1'b1);
      queue_event(MODE_ASK_HIM_ENABLE, 8'd0, 1'b0);
      queue_event(MODE_ASK_HIM_DISABLE, 8'd0, 1'b0);
      queue_event(MODE_GOT_WILL, 8'd0, 1'b1);
      queue_event(MODE_ASK_HIM_DISABLE, 8'd0, 1'b0);
      queue_event(MODE_ASK_HIM_ENABLE, 8'd0, 1'b0);
      queue_event(MODE_GOT_WONT, 8'd0, 1'b0);
      queue_event(MODE_GOT_WONT, 8'd0, 1'b0);

      // Random part. Most events hit a handful of options so that both sides
      // reach the deep WANTNO and WANTYES states with queued requests, often
      // back to back on the same option; the rest are spread over all codes.
      hot_options = '{8'd0, 8'd1, 8'd2, 8'd253, 8'd254, 8'd255};
      repeat (RANDOM_EVENTS) begin
         pick = $urandom_range(99);
         rnd = $urandom_range(7);
         mode_pick = rnd[tnopt_pkg::MODE_W-1:0];
         if (pick < 75) begin
            rnd = $urandom_range(5);
            hot_pick = rnd[2:0];
            option_pick = hot_options[hot_pick];
         end else begin
            rnd = $urandom_range(255);
            option_pick = rnd[tnopt_pkg::OPT_W-1:0];
         end
         queue_event(mode_pick, option_pick, ($urandom_range(99) < 70));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything sent, every reply seen, then a few quiet cycles to
      // catch any stray response.
      while (pending_events.size() != 0 || start || awaited_replies.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fault_count == 0) begin
         $display("PASS telnet_option_negotiator_unit");
      end else begin
         $display("FAIL telnet_option_negotiator_unit");
      end
      $finish;
   end

endmodule

[telnet_option_negotiator_unit.f]
+incdir+hw/rtl
hw/rtl/tnopt_pkg.sv
hw/rtl/tnopt_side.sv
hw/rtl/telnet_option_negotiator_unit.sv
dv/telnet_option_negotiator_unit_tb.sv
